>>> design/command_deque_overwrite_assert.svh
// ----------------------------------------------------------------------------
// Command deque assertions: shared assertion macros
// Each macro expects signals named clk and arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef COMMAND_DEQUE_OVERWRITE_ASSERT_SVH
`define COMMAND_DEQUE_OVERWRITE_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define CDQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a result in the next cycle.
`define CDQ_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cdq_pkg.sv
// ----------------------------------------------------------------------------
// Command deque package
// Shared request and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	// Parameter defaults.
	localparam int DEPTH_DEF      = 16;
	localparam int ENTRY_BITS_DEF = 32;

	// Fixed field widths of the stream payloads.
	localparam int REQ_BITS    = 2;
	localparam int DATA_BITS   = 32;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 5;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 40;

	// Request codes.
	typedef enum logic [REQ_BITS-1:0] {
		REQ_PUSH_BACK  = 2'd0,
		REQ_PUSH_FRONT = 2'd1,
		REQ_POP        = 2'd2
	} req_t;

	// Result status codes.
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

>>> design/cdq_ram.sv
// ----------------------------------------------------------------------------
// Command deque RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/command_deque_overwrite.sv
// ----------------------------------------------------------------------------
// Command deque with overwrite of the oldest entry
// Circular queue in one RAM with front and rear pointers and an entry count.
// Pushes to the back or front, pops from the front; a push into a full queue
// writes at the rear and drops the oldest entry.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tuser: req_type; tdata: entry_data
//  m_axis    out        tuser: status; tdata: read_data, entry_count
//
//  One request is taken per cycle while the output is not stalled; each result
//  passes through the RAM read stage, then the output register.
//  Pointers and count update at the input transfer, so the next request sees
//  them at once; the only memory access per request is at most one write or one read.
//  A stalled output register holds the read stage, which then blocks input.
//  arst_n clears pointers, count and valid flags; RAM contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_deque_overwrite_assert.svh"

module command_deque_overwrite #(
	parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
	parameter int ENTRY_BITS = cdq_pkg::ENTRY_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] entry_data
	input  wire logic [cdq_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [1:0] req_type
	input  wire logic [cdq_pkg::REQ_BITS-1:0]  s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [31:0] read_data, [36:32] entry_count, [39:37] zero
	output logic [cdq_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	// [1:0] status
	output logic [cdq_pkg::STATUS_BITS-1:0]    m_axis_tuser
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PAD_W = cdq_pkg::M_TDATA_W - cdq_pkg::DATA_BITS - cdq_pkg::COUNT_BITS;

	// Queue state.
	logic [PTR_W-1:0] front_q, rear_q;
	logic [CNT_W-1:0] count_q;

	// Read stage and output register.
	logic                                valid_s1;
	cdq_pkg::status_t                    status_s1;
	logic                                pop_s1;
	logic [cdq_pkg::COUNT_BITS-1:0]      count_s1;
	logic                                m_valid_q;
	logic [cdq_pkg::M_TDATA_W-1:0]       m_data_q;
	logic [cdq_pkg::STATUS_BITS-1:0]     m_user_q;

	// Next-state signals.
	logic             s_fire, advance, full, empty;
	logic [PTR_W-1:0] front_d, rear_d, front_next, front_prev, rear_next;
	logic [CNT_W-1:0] count_d;
	cdq_pkg::status_t status_d;
	logic             pop_ok;
	logic             pop_fire;
	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;
	logic [63:0]      wdata_wide, rdata_wide;
	logic [15:0]      count_wide;
	logic [CNT_W:0]   rear_sum;
	logic [PTR_W-1:0] rear_expect;
	logic [CNT_W-1:0] count_dec;
	logic             full_push;
	logic             out_stall;

	// Handshake: the read stage moves on when the output register is free.
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	// Pointer stepping modulo DEPTH.
	assign full       = (count_q == CNT_W'(DEPTH));
	assign empty      = (count_q == '0);
	assign front_next = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + PTR_W'(1);
	assign front_prev = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - PTR_W'(1);
	assign rear_next  = (rear_q == PTR_W'(DEPTH - 1)) ? '0 : rear_q + PTR_W'(1);

	// Store data is masked to the entry width.
	assign wdata_wide = {32'd0, s_axis_tdata};
	assign ram_wdata  = wdata_wide[ENTRY_BITS-1:0];

	// Request decode: pointer, count and memory write for one request.
	always_comb begin
		front_d   = front_q;
		rear_d    = rear_q;
		count_d   = count_q;
		status_d  = cdq_pkg::ST_OK;
		pop_ok    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = rear_q;
		unique case (cdq_pkg::req_t'(s_axis_tuser)) inside
			cdq_pkg::REQ_PUSH_BACK, cdq_pkg::REQ_PUSH_FRONT: begin
				ram_we = s_fire;
				if (full) begin
					rear_d   = rear_next;
					front_d  = front_next;
					status_d = cdq_pkg::ST_FULL;
				end else if (cdq_pkg::req_t'(s_axis_tuser) == cdq_pkg::REQ_PUSH_BACK) begin
					rear_d  = rear_next;
					count_d = count_q + CNT_W'(1);
				end else begin
					front_d   = front_prev;
					ram_waddr = front_prev;
					count_d   = count_q + CNT_W'(1);
				end
			end
			cdq_pkg::REQ_POP: begin
				if (empty) begin
					status_d = cdq_pkg::ST_EMPTY;
				end else begin
					pop_ok  = 1'b1;
					front_d = front_next;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign count_wide = 16'(count_d);
	assign pop_fire   = s_fire && pop_ok;

	// Entry store; a pop reads at the front pointer.
	cdq_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (pop_fire),
		.raddr(front_q),
		.rdata(ram_rdata)
	);

	assign rdata_wide = 64'(ram_rdata);

	// Control state: pointers, count and valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			rear_q    <= '0;
			count_q   <= '0;
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				front_q <= front_d;
				rear_q  <= rear_d;
				count_q <= count_d;
			end
			if (s_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the read stage and the output.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			status_s1 <= status_d;
			pop_s1    <= pop_ok;
			count_s1  <= count_wide[cdq_pkg::COUNT_BITS-1:0];
		end
		if (advance) begin
			m_user_q <= status_s1;
			m_data_q <= {PAD_W'(0), count_s1, pop_s1 ? rdata_wide[31:0] : 32'd0};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// Expected rear pointer from front and count, for checking.
	assign rear_sum    = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(count_q);
	assign rear_expect = (rear_sum >= (CNT_W + 1)'(DEPTH)) ?
		PTR_W'(rear_sum - (CNT_W + 1)'(DEPTH)) : PTR_W'(rear_sum);

	// Helper terms for the checks below.
	assign count_dec = count_q - CNT_W'(1);
	assign full_push = ram_we && full;
	assign out_stall = m_valid_q && !m_axis_tready;

	`CDQ_ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(DEPTH), "entry count exceeds depth")
	`CDQ_ASSERT_ALWAYS(a_ptr_consistent, rear_q == rear_expect, "rear pointer off front plus count")
	`CDQ_ASSERT_NEXT(a_full_push, full_push, status_s1 == cdq_pkg::ST_FULL && full, "full push missed")
	`CDQ_ASSERT_NEXT(a_pop_count, pop_fire, pop_s1 && count_q == $past(count_dec), "pop count off")
	`CDQ_ASSERT_ALWAYS(a_stall_blocks, !(valid_s1 && out_stall && s_axis_tready), "input taken in stall")

endmodule

`default_nettype wire

>>> verif/command_deque_overwrite_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command deque testbench
// Drives requests into the deque, predicts each result with a deque model of
// its own and checks every output transfer field by field, in order. A short
// table of directed requests comes first: reset, empty pop, both extremes of
// the entry data, the unused request code, and pushes of both kinds into a
// full queue. Random traffic follows in segments that lean toward filling,
// draining or holding the queue level, with random gaps and stalls on both
// sides, one long output stall and one full drain.
// ----------------------------------------------------------------------------

module command_deque_overwrite_tb;

	localparam int CLK_HALF      = 5;
	localparam int RANDOM_ITEMS  = 1700;
	localparam int LONG_HOLD     = 64;
	localparam int HOLD_AT       = 600;
	localparam int DRAIN_AT      = 1200;
	localparam int TAIL_CYCLES   = 10;
	localparam int CYCLE_LIMIT   = 200000;

	// The request code the block takes and ignores.
	localparam logic [cdq_pkg::REQ_BITS-1:0] REQ_UNUSED = 2'd3;

	// Leaning of one random segment.
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	typedef struct {
		cdq_pkg::status_t               status;
		logic [cdq_pkg::DATA_BITS-1:0]  rdata;
		logic [cdq_pkg::COUNT_BITS-1:0] count;
	} deque_result_t;

	typedef struct {
		logic [cdq_pkg::REQ_BITS-1:0]  req;
		logic [cdq_pkg::DATA_BITS-1:0] data;
		bit                            typed;
		deque_result_t                 want;
	} stim_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [cdq_pkg::S_TDATA_W-1:0]     s_axis_tdata = '0;
	logic [cdq_pkg::REQ_BITS-1:0]      s_axis_tuser = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [cdq_pkg::M_TDATA_W-1:0]     m_axis_tdata;
	logic [cdq_pkg::STATUS_BITS-1:0]   m_axis_tuser;

	// Deque model state.
	logic [cdq_pkg::DATA_BITS-1:0] model_store [cdq_pkg::DEPTH_DEF];
	int                            model_front = 0;
	int                            model_rear = 0;
	int                            model_held = 0;

	deque_result_t pending_results[$];
	int            error_count = 0;
	int            cycle_count = 0;
	bit            sender_burst = 1'b0;
	bit            hold_output_req = 1'b0;

	command_deque_overwrite #(
		.DEPTH      (cdq_pkg::DEPTH_DEF),
		.ENTRY_BITS (cdq_pkg::ENTRY_BITS_DEF)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #CLK_HALF clk = ~clk;

	function automatic int ptr_next(int p);
		return (p == cdq_pkg::DEPTH_DEF - 1) ? 0 : p + 1;
	endfunction

	// Apply one request to the deque model and return the result it causes.
	function automatic deque_result_t deque_apply(logic [cdq_pkg::REQ_BITS-1:0] req,
			logic [cdq_pkg::DATA_BITS-1:0] data);
		deque_result_t r;
		r.status = cdq_pkg::ST_OK;
		r.rdata  = '0;
		if (req == cdq_pkg::REQ_PUSH_BACK || req == cdq_pkg::REQ_PUSH_FRONT) begin
			if (model_held == cdq_pkg::DEPTH_DEF) begin
				// A full queue takes either push at the rear and drops the oldest.
				model_store[model_rear] = data;
				model_rear  = ptr_next(model_rear);
				model_front = ptr_next(model_front);
				r.status    = cdq_pkg::ST_FULL;
			end else if (req == cdq_pkg::REQ_PUSH_BACK) begin
				model_store[model_rear] = data;
				model_rear = ptr_next(model_rear);
				model_held++;
			end else begin
				model_front = (model_front == 0) ? cdq_pkg::DEPTH_DEF - 1 : model_front - 1;
				model_store[model_front] = data;
				model_held++;
			end
		end else if (req == cdq_pkg::REQ_POP) begin
			if (model_held == 0) begin
				r.status = cdq_pkg::ST_EMPTY;
			end else begin
				r.rdata     = model_store[model_front];
				model_front = ptr_next(model_front);
				model_held--;
			end
		end
		r.count = model_held[cdq_pkg::COUNT_BITS-1:0];
		return r;
	endfunction

	// Compare one output transfer with the oldest expected result.
	function automatic void check_result(logic [cdq_pkg::STATUS_BITS-1:0] st,
			logic [cdq_pkg::M_TDATA_W-1:0] td);
		deque_result_t want;
		if (pending_results.size() == 0) begin
			$error("result transfer with no request pending: status %0d, tdata %h", st, td);
			error_count++;
			return;
		end
		want = pending_results.pop_front();
		if (st !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, st);
			error_count++;
		end
		if (td[cdq_pkg::DATA_BITS-1:0] !== want.rdata) begin
			$error("read_data: expected %h, got %h", want.rdata,
				td[cdq_pkg::DATA_BITS-1:0]);
			error_count++;
		end
		if (td[cdq_pkg::DATA_BITS+cdq_pkg::COUNT_BITS-1:cdq_pkg::DATA_BITS] !== want.count)
		begin
			$error("entry_count: expected %0d, got %0d", want.count,
				td[cdq_pkg::DATA_BITS+cdq_pkg::COUNT_BITS-1:cdq_pkg::DATA_BITS]);
			error_count++;
		end
		if (td[cdq_pkg::M_TDATA_W-1:cdq_pkg::DATA_BITS+cdq_pkg::COUNT_BITS] !== '0) begin
			$error("tdata padding: expected 0, got %h",
				td[cdq_pkg::M_TDATA_W-1:cdq_pkg::DATA_BITS+cdq_pkg::COUNT_BITS]);
			error_count++;
		end
	endfunction

	function automatic stim_row_t row(logic [cdq_pkg::REQ_BITS-1:0] req,
			logic [cdq_pkg::DATA_BITS-1:0] data, bit typed, cdq_pkg::status_t st,
			logic [cdq_pkg::DATA_BITS-1:0] rd, int cnt);
		stim_row_t s;
		s.req         = req;
		s.data        = data;
		s.typed       = typed;
		s.want.status = st;
		s.want.rdata  = rd;
		s.want.count  = cnt[cdq_pkg::COUNT_BITS-1:0];
		return s;
	endfunction

	// Offer one request after a random gap, none in a burst, and record its
	// expected result once the transfer happens.
	task automatic send_item(logic [cdq_pkg::REQ_BITS-1:0] req,
			logic [cdq_pkg::DATA_BITS-1:0] data, bit typed, deque_result_t typed_want);
		int            gap;
		deque_result_t predicted;
		gap = sender_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= data;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		predicted = deque_apply(req, data);
		pending_results.push_back(typed ? typed_want : predicted);
	endtask

	// Lower valid and wait until every expected result has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Output side: random stalls, stretches without stalls, and one long hold
	// when the stimulus asks for it.
	initial begin : result_sink
		int stall;
		int calm_left;
		calm_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_output_req) begin
				hold_output_req = 1'b0;
				stall = LONG_HOLD;
			end else if (calm_left > 0) begin
				calm_left--;
				stall = 0;
			end else begin
				stall = $urandom_range(0, 8);
				if ($urandom_range(0, 15) == 0)
					calm_left = $urandom_range(10, 40);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
			check_result(m_axis_tuser, m_axis_tdata);
		end
	end

	// Run limit.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** command_deque_overwrite: FAILED **");
		$finish;
	end

	initial begin : stimulus
		stim_row_t                     directed[$];
		deque_result_t                 no_want;
		logic [cdq_pkg::REQ_BITS-1:0]  req;
		logic [cdq_pkg::DATA_BITS-1:0] data;
		mix_t                          mix;
		int                            seg_left;
		int                            done_items;
		int                            pick;
		int                            push_pct;
		bit                            hold_done;
		bit                            drain_done;

		no_want   = '{cdq_pkg::ST_OK, '0, '0};
		seg_left  = 0;
		done_items = 0;
		mix       = MIX_EVEN;
		hold_done = 1'b0;
		drain_done = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty pop, unused code, data extremes, the pop after a
		// push to front, then fill up and push of both kinds into a full queue.
		directed.push_back(row(cdq_pkg::REQ_POP, 32'h0000_0000, 1,
			cdq_pkg::ST_EMPTY, 32'h0, 0));
		directed.push_back(row(REQ_UNUSED, 32'hFFFF_FFFF, 1,
			cdq_pkg::ST_OK, 32'h0, 0));
		directed.push_back(row(cdq_pkg::REQ_PUSH_BACK, 32'h0000_0000, 1,
			cdq_pkg::ST_OK, 32'h0, 1));
		directed.push_back(row(cdq_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF, 1,
			cdq_pkg::ST_OK, 32'h0, 2));
		directed.push_back(row(cdq_pkg::REQ_PUSH_FRONT, 32'hA5A5_A5A5, 1,
			cdq_pkg::ST_OK, 32'h0, 3));
		directed.push_back(row(cdq_pkg::REQ_POP, 32'hFFFF_FFFF, 1,
			cdq_pkg::ST_OK, 32'hA5A5_A5A5, 2));
		directed.push_back(row(cdq_pkg::REQ_POP, 32'h0000_0000, 1,
			cdq_pkg::ST_OK, 32'h0, 1));
		for (int i = 0; i < 15; i++)
			directed.push_back(row((i % 2) ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_BACK,
				32'h1000_0000 + i * 32'h0101_0101, 0, cdq_pkg::ST_OK, 32'h0, 0));
		directed.push_back(row(cdq_pkg::REQ_PUSH_BACK, 32'h5A5A_5A5A, 1,
			cdq_pkg::ST_FULL, 32'h0, 16));
		directed.push_back(row(cdq_pkg::REQ_PUSH_FRONT, 32'h3C3C_3C3C, 1,
			cdq_pkg::ST_FULL, 32'h0, 16));
		directed.push_back(row(cdq_pkg::REQ_POP, 32'h0000_0000, 0,
			cdq_pkg::ST_OK, 32'h0, 0));

		foreach (directed[i])
			send_item(directed[i].req, directed[i].data, directed[i].typed, directed[i].want);

		// Random traffic in segments of one leaning each.
		while (done_items < RANDOM_ITEMS) begin
			if (seg_left == 0) begin
				seg_left     = $urandom_range(20, 80);
				mix          = mix_t'($urandom_range(0, 2));
				sender_burst = ($urandom_range(0, 3) == 0);
			end
			if (!hold_done && done_items >= HOLD_AT) begin
				// Long output stall while requests keep coming back to back.
				hold_done       = 1'b1;
				hold_output_req = 1'b1;
				sender_burst    = 1'b1;
				seg_left        = 40;
				mix             = MIX_FILL;
			end
			if (!drain_done && done_items >= DRAIN_AT) begin
				drain_done = 1'b1;
				drain_results();
			end

			case (mix)
				MIX_FILL:  push_pct = 75;
				MIX_DRAIN: push_pct = 25;
				default:   push_pct = 50;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 3)
				req = REQ_UNUSED;
			else if (pick < 3 + push_pct * 97 / 100)
				req = $urandom_range(0, 1) ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_BACK;
			else
				req = cdq_pkg::REQ_POP;

			case ($urandom_range(0, 9))
				0:       data = '0;
				1:       data = '1;
				default: data = $urandom();
			endcase

			send_item(req, data, 1'b0, no_want);
			seg_left--;
			if (req != REQ_UNUSED)
				done_items++;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("** command_deque_overwrite: PASSED **");
		else
			$display("** command_deque_overwrite: FAILED **");
		$finish;
	end

endmodule
